[hw/rtl/stkqu_pkg.sv]
package stkqu_pkg;

	// default widths of the data and angle fields
	localparam int DATA_W_DEF  = 32;
	localparam int ANGLE_W_DEF = 16;

	// q30 fixed point: 1.0 = 2^30
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [29:0] PI4_Q30 = 30'd843314857;

	// series terms for sin and cos, each one multiply and one divide by a constant
	localparam int NUM_TERMS = 4;

	// divide by constant: floor(n / d) = (n * recip) >> shift, exact for n < 2^30
	typedef logic [30:0] recip_t;
	localparam recip_t SIN_RECIP [NUM_TERMS] = '{
		31'd1908874354,	// 72
		31'd1636178018,	// 42
		31'd1717986919,	// 20
		31'd1431655766	// 6
	};
	localparam int SIN_SHIFT [NUM_TERMS] = '{37, 36, 35, 33};
	localparam recip_t COS_RECIP [NUM_TERMS] = '{
		31'd1527099484,	// 90
		31'd1227133514,	// 56
		31'd1145324613,	// 30
		31'd1431655766	// 12
	};
	localparam int COS_SHIFT [NUM_TERMS] = '{37, 36, 35, 34};

	// trig terms in q1.17, signed, magnitude up to 1.0
	localparam int TRIG_W = 19;
	typedef logic signed [TRIG_W-1:0] trig_t;

	// capture, angle, square, two stages per term, then seven finishing stages
	localparam int PIPE_LAT = 2 * NUM_TERMS + 10;

	// configuration register indexes
	localparam int CFG_ADDR_W = 1;
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_REF_ANGLE     = 1'b0,
		REG_VARIANCE_MODE = 1'b1
	} cfg_reg_t;

endpackage

[hw/rtl/stokes_qu_rotation.sv]
// Rotates Stokes Q and U of one pixel per clock from the old reference direction (beta,
// measured from grid X) to ref_angle, or, with variance_mode set, combines the variances
// with squared trig terms. An item is taken at every rising edge with start high; busy
// stays low, as the block never holds off input. Each result is transferred with done high
// for one cycle, in input order; the receiver cannot stall it and need not. The multiplier
// pipeline has one capture stage, one stage for the angle, one for its square, two per
// series term (four terms for sin and cos side by side), one for the last sin and cos
// products, then rounding, quadrant placement, squaring, operand select, the multiply-add
// and the final rounding with saturation. Write ref_angle and variance_mode only while no
// item is in flight; a bad flag on any input gives zero outputs with out_good low.
module stokes_qu_rotation
	import stkqu_pkg::*;
#(
	parameter int DATA_WIDTH  = DATA_W_DEF,
	parameter int ANGLE_WIDTH = ANGLE_W_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0]         cfg_addr,
	input  logic [ANGLE_WIDTH-1:0]        cfg_wdata,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [DATA_WIDTH-1:0]  q_in,
	input  logic signed [DATA_WIDTH-1:0]  u_in,
	input  logic [ANGLE_WIDTH-1:0]        beta,
	input  logic                          q_good,
	input  logic                          u_good,
	input  logic                          beta_good,
	output logic                          done,
	output logic signed [DATA_WIDTH-1:0]  q_out,
	output logic signed [DATA_WIDTH-1:0]  u_out,
	output logic                          out_good,
	output logic                          saturated
);

	localparam int SUM_W = DATA_WIDTH + TRIG_W + 1;
	localparam int RND_W = SUM_W - 17;
	localparam int TOP_W = RND_W - DATA_WIDTH + 1;
	localparam logic [60:0] RND30 = 61'd1 << 29;

	typedef struct packed {
		logic                         good;
		logic [2:0]                   oct;
		logic signed [DATA_WIDTH-1:0] q;
		logic signed [DATA_WIDTH-1:0] u;
		logic [29:0]                  x;
		logic [29:0]                  x2;
	} side_t;

	logic [ANGLE_WIDTH-1:0] ref_angle_q;
	logic                   var_mode_q;
	logic                   take;
	logic [PIPE_LAT:1]      vld_s;
	side_t                  side_s [1:PIPE_LAT-1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_angle_q <= '0;
			var_mode_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_REF_ANGLE:     ref_angle_q <= cfg_wdata;
				REG_VARIANCE_MODE: var_mode_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// no backpressure: every start is a transfer
	assign busy = 1'b0;
	assign take = start & ~busy;

	// valid bits travel with the items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[PIPE_LAT-1:1], take};
		end
	end
	assign done = vld_s[PIPE_LAT];

	// stage 1: doubled rotation angle, octant and folded octant fraction
	logic [ANGLE_WIDTH-1:0] rot;
	logic [ANGLE_WIDTH-1:0] dbl;
	logic [28:0]            frac;
	logic [29:0]            ffold;
	logic [29:0]            f_s1;

	assign rot   = beta - ref_angle_q;
	assign dbl   = {rot[ANGLE_WIDTH-2:0], 1'b0};
	assign frac  = {dbl[ANGLE_WIDTH-4:0], {(32 - ANGLE_WIDTH){1'b0}}};
	assign ffold = dbl[ANGLE_WIDTH-3] ? (30'h2000_0000 - {1'b0, frac}) : {1'b0, frac};

	always_ff @(posedge clk) begin
		f_s1           <= ffold;
		side_s[1].good <= q_good & u_good & beta_good;
		side_s[1].oct  <= dbl[ANGLE_WIDTH-1:ANGLE_WIDTH-3];
		side_s[1].q    <= q_in;
		side_s[1].u    <= u_in;
		side_s[1].x    <= '0;
		side_s[1].x2   <= '0;
	end

	// stage 2: angle in radians, x = round(f * pi/4 / 2^29)
	logic [59:0] x_prod;
	assign x_prod = 60'(f_s1) * 60'(PI4_Q30) + (60'd1 << 28);

	always_ff @(posedge clk) begin
		side_s[2]   <= side_s[1];
		side_s[2].x <= x_prod[58:29];
	end

	// stage 3: x squared in q30
	logic [59:0] x2_prod;
	assign x2_prod = 60'(side_s[2].x) * 60'(side_s[2].x) + (60'd1 << 29);

	always_ff @(posedge clk) begin
		side_s[3]    <= side_s[2];
		side_s[3].x2 <= x2_prod[59:30];
	end

	// side line for the remaining stages
	for (genvar k = 4; k < PIPE_LAT; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[k] <= side_s[k-1];
		end
	end

	// stages 4 to 11: horner terms t = 1 - x2 * t / d, sin and cos side by side
	logic [29:0] sin_p_s    [NUM_TERMS];
	logic [29:0] cos_p_s    [NUM_TERMS];
	logic [29:0] sin_quot_s [NUM_TERMS];
	logic [29:0] cos_quot_s [NUM_TERMS];

	for (genvar i = 0; i < NUM_TERMS; i++) begin : g_term
		logic [30:0] t_sin;
		logic [30:0] t_cos;
		logic [60:0] sin_mul;
		logic [60:0] cos_mul;
		logic [60:0] sin_div;
		logic [60:0] cos_div;

		if (i == 0) begin : g_first
			assign t_sin = Q30_ONE;
			assign t_cos = Q30_ONE;
		end else begin : g_next
			assign t_sin = Q30_ONE - {1'b0, sin_quot_s[i-1]};
			assign t_cos = Q30_ONE - {1'b0, cos_quot_s[i-1]};
		end

		// multiply by x2, rounded to q30
		assign sin_mul = 61'(side_s[3+2*i].x2) * 61'(t_sin) + RND30;
		assign cos_mul = 61'(side_s[3+2*i].x2) * 61'(t_cos) + RND30;

		always_ff @(posedge clk) begin
			sin_p_s[i] <= sin_mul[59:30];
			cos_p_s[i] <= cos_mul[59:30];
		end

		// divide by the series constant, truncating
		assign sin_div = 61'(sin_p_s[i]) * 61'(SIN_RECIP[i]);
		assign cos_div = 61'(cos_p_s[i]) * 61'(COS_RECIP[i]);

		always_ff @(posedge clk) begin
			sin_quot_s[i] <= 30'(sin_div >> SIN_SHIFT[i]);
			cos_quot_s[i] <= 30'(cos_div >> COS_SHIFT[i]);
		end
	end

	// stage 12: s = x * t_sin, and x2 * t_cos for the last cos term
	logic [30:0] t_sin_last;
	logic [30:0] t_cos_last;
	logic [60:0] s_mul;
	logic [60:0] c_mul;
	logic [29:0] s_raw_s12;
	logic [29:0] cp_s12;

	assign t_sin_last = Q30_ONE - {1'b0, sin_quot_s[NUM_TERMS-1]};
	assign t_cos_last = Q30_ONE - {1'b0, cos_quot_s[NUM_TERMS-1]};
	assign s_mul = 61'(side_s[11].x) * 61'(t_sin_last) + RND30;
	assign c_mul = 61'(side_s[11].x2) * 61'(t_cos_last) + RND30;

	always_ff @(posedge clk) begin
		s_raw_s12 <= s_mul[59:30];
		cp_s12    <= c_mul[59:30];
	end

	// stage 13: finish cos and round both to q1.17
	logic [30:0] c_full;
	logic [31:0] c_rnd;
	logic [30:0] s_rnd;
	logic [17:0] sq_s13;
	logic [17:0] cq_s13;

	assign c_full = Q30_ONE - {2'b00, cp_s12[29:1]};
	assign c_rnd  = {1'b0, c_full} + 32'd4096;
	assign s_rnd  = {1'b0, s_raw_s12} + 31'd4096;

	always_ff @(posedge clk) begin
		sq_s13 <= s_rnd[30:13];
		cq_s13 <= c_rnd[30:13];
	end

	// stage 14: place the octant result in its quadrant
	logic  swap;
	logic  neg_s;
	logic  neg_c;
	trig_t mag_s;
	trig_t mag_c;
	trig_t s_s14;
	trig_t c_s14;

	assign swap  = side_s[13].oct[0] ^ side_s[13].oct[1];
	assign neg_s = side_s[13].oct[2];
	assign neg_c = side_s[13].oct[1] ^ side_s[13].oct[2];
	assign mag_s = swap ? trig_t'({1'b0, cq_s13}) : trig_t'({1'b0, sq_s13});
	assign mag_c = swap ? trig_t'({1'b0, sq_s13}) : trig_t'({1'b0, cq_s13});

	always_ff @(posedge clk) begin
		s_s14 <= neg_s ? -mag_s : mag_s;
		c_s14 <= neg_c ? -mag_c : mag_c;
	end

	// stage 15: squares for variance mode
	logic signed [2*TRIG_W-1:0] c_sqr;
	logic signed [2*TRIG_W-1:0] s_sqr;
	logic [34:0]                csq_s15;
	logic [34:0]                ssq_s15;
	trig_t                      c_s15;
	trig_t                      s_s15;

	assign c_sqr = c_s14 * c_s14;
	assign s_sqr = s_s14 * s_s14;

	always_ff @(posedge clk) begin
		csq_s15 <= c_sqr[34:0];
		ssq_s15 <= s_sqr[34:0];
		c_s15   <= c_s14;
		s_s15   <= s_s14;
	end

	// stage 16: operand select per mode
	logic [35:0] c2_rnd;
	logic [35:0] s2_rnd;
	trig_t       c2;
	trig_t       s2;
	trig_t       pc_s16;
	trig_t       pqs_s16;
	trig_t       pus_s16;

	assign c2_rnd = {1'b0, csq_s15} + 36'd65536;
	assign s2_rnd = {1'b0, ssq_s15} + 36'd65536;
	assign c2     = trig_t'({1'b0, c2_rnd[34:17]});
	assign s2     = trig_t'({1'b0, s2_rnd[34:17]});

	always_ff @(posedge clk) begin
		pc_s16  <= var_mode_q ? c2 : c_s15;
		pqs_s16 <= var_mode_q ? s2 : -s_s15;
		pus_s16 <= var_mode_q ? s2 : s_s15;
	end

	// stage 17: exact multiply-add for both outputs
	logic signed [SUM_W-1:0] q_sum;
	logic signed [SUM_W-1:0] u_sum;
	logic signed [SUM_W-1:0] q_sum_s17;
	logic signed [SUM_W-1:0] u_sum_s17;

	assign q_sum = $signed(side_s[16].q) * pc_s16 + $signed(side_s[16].u) * pqs_s16;
	assign u_sum = $signed(side_s[16].u) * pc_s16 + $signed(side_s[16].q) * pus_s16;

	always_ff @(posedge clk) begin
		q_sum_s17 <= q_sum;
		u_sum_s17 <= u_sum;
	end

	// stage 18: round half up by 2^17, saturate, zero bad pixels
	logic signed [SUM_W-1:0]      q_adj;
	logic signed [SUM_W-1:0]      u_adj;
	logic [RND_W-1:0]             q_r;
	logic [RND_W-1:0]             u_r;
	logic [TOP_W-1:0]             q_top;
	logic [TOP_W-1:0]             u_top;
	logic                         q_ovf;
	logic                         u_ovf;
	logic signed [DATA_WIDTH-1:0] q_clamp;
	logic signed [DATA_WIDTH-1:0] u_clamp;
	logic signed [DATA_WIDTH-1:0] max_val;
	logic signed [DATA_WIDTH-1:0] min_val;

	assign q_adj   = q_sum_s17 + $signed(SUM_W'(65536));
	assign u_adj   = u_sum_s17 + $signed(SUM_W'(65536));
	assign q_r     = q_adj[SUM_W-1:17];
	assign u_r     = u_adj[SUM_W-1:17];
	assign q_top   = q_r[RND_W-1:DATA_WIDTH-1];
	assign u_top   = u_r[RND_W-1:DATA_WIDTH-1];
	assign q_ovf   = ~(&q_top | ~|q_top);
	assign u_ovf   = ~(&u_top | ~|u_top);
	assign max_val = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
	assign min_val = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
	assign q_clamp = q_ovf ? (q_r[RND_W-1] ? min_val : max_val) : q_r[DATA_WIDTH-1:0];
	assign u_clamp = u_ovf ? (u_r[RND_W-1] ? min_val : max_val) : u_r[DATA_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (side_s[17].good) begin
			q_out     <= q_clamp;
			u_out     <= u_clamp;
			out_good  <= 1'b1;
			saturated <= q_ovf | u_ovf;
		end else begin
			q_out     <= '0;
			u_out     <= '0;
			out_good  <= 1'b0;
			saturated <= 1'b0;
		end
	end

endmodule

[hw/rtl/stkqu_chk.sv]
module stkqu_chk
	import stkqu_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_W_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         q_good,
	input logic                         u_good,
	input logic                         beta_good,
	input logic                         done,
	input logic signed [DATA_WIDTH-1:0] q_out,
	input logic signed [DATA_WIDTH-1:0] u_out,
	input logic                         out_good,
	input logic                         saturated
);

	localparam logic [DATA_WIDTH-1:0] MAX_VAL = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MIN_VAL = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

	// every input transfer yields a result after the fixed latency
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("result missing after input transfer");

	// no result without an input transfer
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without input transfer");

	// good result only from all-good inputs
	a_good: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_good) |-> $past(q_good && u_good && beta_good, PIPE_LAT))
		else $error("good result from bad input");

	// bad pixels come out zeroed and unsaturated
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_good) |-> (q_out == '0 && u_out == '0 && !saturated))
		else $error("bad pixel not zeroed");

	// a saturated result sits on a range limit
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturated) |-> (q_out == MAX_VAL || q_out == MIN_VAL ||
			u_out == MAX_VAL || u_out == MIN_VAL))
		else $error("saturation flag without clamped output");

endmodule

bind stokes_qu_rotation stkqu_chk #(.DATA_WIDTH(DATA_WIDTH)) u_stkqu_chk (.*);

[bench/stokes_qu_rotation_checker.sv]
module stokes_qu_rotation_checker
	import stkqu_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [15:0]           cfg_wdata,
	input  logic                  start,
	input  logic                  busy,
	input  logic signed [31:0]    q_in,
	input  logic signed [31:0]    u_in,
	input  logic [15:0]           beta,
	input  logic                  q_good,
	input  logic                  u_good,
	input  logic                  beta_good,
	input  logic                  done,
	input  logic signed [31:0]    q_out,
	input  logic signed [31:0]    u_out,
	input  logic                  out_good,
	input  logic                  saturated,
	output int                    fail_count,
	output int                    pending
);

	localparam logic [63:0] Q30_UNIT = 64'd1 << 30;
	localparam logic [63:0] OCT_UNIT = 64'd1 << 29;
	localparam longint DATA_MAX = 64'sd2147483647;
	localparam longint DATA_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] q;
		logic signed [31:0] u;
		logic [15:0]        beta;
		logic               q_good;
		logic               u_good;
		logic               beta_good;
	} pixel_in_t;

	typedef struct packed {
		logic signed [31:0] q;
		logic signed [31:0] u;
		logic               good;
		logic               sat;
	} pixel_result_t;

	typedef struct packed {
		trig_t c;
		trig_t s;
	} trig_pair_t;

	logic [15:0] ref_angle_r = '0;
	logic        var_mode_r  = 1'b0;
	pixel_result_t rotated_q[$];

	// q30 product, rounded half up
	function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
		return (a * b + (64'd1 << 29)) >> 30;
	endfunction

	// cos and sin of a binary angle in q1.17
	function automatic trig_pair_t cos_sin_q17(input logic [15:0] ang);
		logic [31:0] turn;
		int          oct;
		logic [63:0] f, x, x2, t, sn, cs, sq, cq;
		trig_t       vs, vc;
		trig_pair_t  tp;
		turn = {ang, 16'd0};
		oct = int'(turn[31:29]);
		f = 64'(turn[28:0]);
		// odd octants count back from the next axis
		if (oct[0])
			f = OCT_UNIT - f;
		x = (f * 64'(PI4_Q30) + (64'd1 << 28)) >> 29;
		x2 = q30_mul(x, x);
		// sine series to x^9
		t = Q30_UNIT - x2 / 72;
		t = Q30_UNIT - q30_mul(x2, t) / 42;
		t = Q30_UNIT - q30_mul(x2, t) / 20;
		t = Q30_UNIT - q30_mul(x2, t) / 6;
		sn = q30_mul(x, t);
		// cosine series to x^10
		t = Q30_UNIT - x2 / 90;
		t = Q30_UNIT - q30_mul(x2, t) / 56;
		t = Q30_UNIT - q30_mul(x2, t) / 30;
		t = Q30_UNIT - q30_mul(x2, t) / 12;
		cs = Q30_UNIT - q30_mul(x2, t) / 2;
		sq = (sn + (64'd1 << 12)) >> 13;
		cq = (cs + (64'd1 << 12)) >> 13;
		// quadrant placement by symmetry
		if ((((oct + 1) >> 1) & 1) != 0) begin
			vs = trig_t'(cq);
			vc = trig_t'(sq);
		end else begin
			vs = trig_t'(sq);
			vc = trig_t'(cq);
		end
		if (oct >= 4)
			vs = -vs;
		if (oct >= 2 && oct <= 5)
			vc = -vc;
		tp.c = vc;
		tp.s = vs;
		return tp;
	endfunction

	// (a*p + b*r) / 2^17, rounded half toward plus infinity
	function automatic longint mac_round(input longint a, input longint p, input longint b,
			input longint r);
		return (a * p + b * r + 64'sd65536) >>> 17;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > DATA_MAX)
			return 32'h7FFF_FFFF;
		if (v < DATA_MIN)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

	// expected result of one pixel under the current register settings
	function automatic pixel_result_t rotate_pixel(input pixel_in_t px, input logic [15:0] ref_ang,
			input logic var_mode);
		pixel_result_t r;
		logic [15:0]   rot;
		trig_pair_t    tp;
		longint        c, s, qv, uv, qo, uo;
		r = '0;
		if (!(px.q_good && px.u_good && px.beta_good))
			return r;
		rot = px.beta - ref_ang;
		tp = cos_sin_q17({rot[14:0], 1'b0});
		c = $signed(tp.c);
		s = $signed(tp.s);
		qv = $signed(px.q);
		uv = $signed(px.u);
		if (var_mode) begin
			c = (c * c + 64'sd65536) >>> 17;
			s = (s * s + 64'sd65536) >>> 17;
			qo = mac_round(qv, c, uv, s);
		end else begin
			qo = mac_round(qv, c, uv, -s);
		end
		uo = mac_round(uv, c, qv, s);
		r.q = clamp32(qo);
		r.u = clamp32(uo);
		r.good = 1'b1;
		r.sat = ($signed(r.q) != qo) || ($signed(r.u) != uo);
		return r;
	endfunction

	// track registers, predict each input transfer, check each result transfer
	always @(posedge clk or negedge arst_n) begin
		pixel_result_t want;
		pixel_in_t     px;
		int            errs;
		if (!arst_n) begin
			ref_angle_r <= '0;
			var_mode_r <= 1'b0;
			rotated_q.delete();
			pending <= 0;
		end else begin
			errs = 0;
			if (done) begin
				if (rotated_q.size() == 0) begin
					$display("%0t: result transfer with no pixel outstanding", $time);
					errs++;
				end else begin
					want = rotated_q.pop_front();
					if (q_out !== want.q) begin
						$display("%0t: q_out expected %0d, got %0d", $time,
							$signed(want.q), q_out);
						errs++;
					end
					if (u_out !== want.u) begin
						$display("%0t: u_out expected %0d, got %0d", $time,
							$signed(want.u), u_out);
						errs++;
					end
					if (out_good !== want.good) begin
						$display("%0t: out_good expected %0b, got %0b", $time,
							want.good, out_good);
						errs++;
					end
					if (saturated !== want.sat) begin
						$display("%0t: saturated expected %0b, got %0b", $time,
							want.sat, saturated);
						errs++;
					end
				end
			end
			if (start && !busy) begin
				px = {q_in, u_in, beta, q_good, u_good, beta_good};
				rotated_q.push_back(rotate_pixel(px, ref_angle_r, var_mode_r));
			end
			if (cfg_wr_en) begin
				case (cfg_addr)
					REG_REF_ANGLE:     ref_angle_r <= cfg_wdata;
					REG_VARIANCE_MODE: var_mode_r <= cfg_wdata[0];
					default:           ;
				endcase
			end
			pending <= rotated_q.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

[bench/stokes_qu_rotation_test.sv]
module stokes_qu_rotation_test;
	import stkqu_pkg::*;

	localparam logic signed [31:0] DMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] DMIN = 32'sh8000_0000;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 215;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [15:0]           cfg_wdata = '0;
	logic                  start     = 1'b0;
	logic signed [31:0]    q_in      = '0;
	logic signed [31:0]    u_in      = '0;
	logic [15:0]           beta      = '0;
	logic                  q_good    = 1'b0;
	logic                  u_good    = 1'b0;
	logic                  beta_good = 1'b0;
	logic                  busy;
	logic                  done;
	logic signed [31:0]    q_out;
	logic signed [31:0]    u_out;
	logic                  out_good;
	logic                  saturated;
	int                    fail_count;
	int                    pending;
	int                    stall_cycles = 0;
	bit                    idle_on = 1'b1;

	always #5 clk = ~clk;

	stokes_qu_rotation u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.busy      (busy),
		.q_in      (q_in),
		.u_in      (u_in),
		.beta      (beta),
		.q_good    (q_good),
		.u_good    (u_good),
		.beta_good (beta_good),
		.done      (done),
		.q_out     (q_out),
		.u_out     (u_out),
		.out_good  (out_good),
		.saturated (saturated)
	);

	stokes_qu_rotation_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_addr   (cfg_addr),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.q_in       (q_in),
		.u_in       (u_in),
		.beta       (beta),
		.q_good     (q_good),
		.u_good     (u_good),
		.beta_good  (beta_good),
		.done       (done),
		.q_out      (q_out),
		.u_out      (u_out),
		.out_good   (out_good),
		.saturated  (saturated),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// one pixel transfer, with a random gap ahead of it when idle_on is set
	task automatic send_pixel(input logic signed [31:0] q, input logic signed [31:0] u,
			input logic [15:0] b, input logic qg, input logic ug, input logic bg);
		while (idle_on && $urandom_range(99) < 19) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		q_in <= q;
		u_in <= u;
		beta <= b;
		q_good <= qg;
		u_good <= ug;
		beta_good <= bg;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// hold off input until every outstanding pixel has come back
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// write both registers; spare data bits on the mode write carry noise
	task automatic set_config(input logic [15:0] ref_ang, input logic var_mode);
		cfg_wr_en <= 1'b1;
		cfg_addr <= REG_REF_ANGLE;
		cfg_wdata <= ref_ang;
		@(posedge clk);
		cfg_addr <= REG_VARIANCE_MODE;
		cfg_wdata <= (16'($urandom) & 16'hFFFE) | 16'(var_mode);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [31:0] pick_data();
		case ($urandom_range(9))
			0: return DMAX;
			1: return DMIN;
			2: return '0;
			3: return 32'($urandom_range(2000)) - 32'd1000;
			4: return $urandom >> $urandom_range(31);
			5: return -($urandom >> $urandom_range(31));
			default: return $urandom;
		endcase
	endfunction

	// near the octant boundaries now and then
	function automatic logic [15:0] pick_angle();
		if ($urandom_range(3) == 0)
			return 16'($urandom_range(15) << 12) + 16'($urandom_range(2)) - 16'd1;
		return 16'($urandom);
	endfunction

	task automatic send_random;
		logic qg, ug, bg;
		if ($urandom_range(99) < 85) begin
			qg = 1'b1;
			ug = 1'b1;
			bg = 1'b1;
		end else begin
			qg = 1'($urandom);
			ug = 1'($urandom);
			bg = 1'($urandom);
		end
		send_pixel(pick_data(), pick_data(), pick_angle(), qg, ug, bg);
	endtask

	initial begin
		logic [15:0] phase_ref [6];
		logic        phase_var [6];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: exact axes, diagonals, clamping and bad flags
		send_pixel(DMAX, 32'sd0, 16'h0000, 1'b1, 1'b1, 1'b1);
		send_pixel(DMIN, DMIN, 16'h0000, 1'b1, 1'b1, 1'b1);
		send_pixel(DMAX, DMAX, 16'h1000, 1'b1, 1'b1, 1'b1);
		send_pixel(DMIN, DMIN, 16'h1000, 1'b1, 1'b1, 1'b1);
		send_pixel(DMIN, 32'sd0, 16'h4000, 1'b1, 1'b1, 1'b1);
		send_pixel(DMAX, DMIN, 16'h2000, 1'b1, 1'b1, 1'b1);
		send_pixel(-32'sd1, 32'sd1, 16'h6000, 1'b1, 1'b1, 1'b1);
		send_pixel(32'sd12345, -32'sd6789, 16'hFFFF, 1'b1, 1'b1, 1'b1);
		send_pixel(32'sd1, 32'sd1, 16'h0800, 1'b1, 1'b1, 1'b1);
		send_pixel(DMAX, DMAX, 16'h1234, 1'b0, 1'b1, 1'b1);
		send_pixel(DMIN, DMAX, 16'h1234, 1'b1, 1'b0, 1'b1);
		send_pixel(DMAX, DMIN, 16'h1234, 1'b1, 1'b1, 1'b0);
		send_pixel(DMAX, DMAX, 16'hFFFF, 1'b0, 1'b0, 1'b0);
		drain();

		// variance mode with the top reference angle
		set_config(16'hFFFF, 1'b1);
		send_pixel(DMAX, DMAX, 16'h0000, 1'b1, 1'b1, 1'b1);
		send_pixel(DMIN, DMIN, 16'h1001, 1'b1, 1'b1, 1'b1);
		send_pixel(32'sd0, DMAX, 16'h2001, 1'b1, 1'b1, 1'b1);
		send_pixel(DMAX, 32'sd0, 16'h0FFF, 1'b1, 1'b1, 1'b1);
		send_pixel(32'sd12345, 32'sd678, 16'h8000, 1'b1, 1'b1, 1'b0);
		drain();

		// half-turn reference, value mode
		set_config(16'h8000, 1'b0);
		send_pixel(DMAX, DMAX, 16'h8000, 1'b1, 1'b1, 1'b1);
		send_pixel(-32'sd7, 32'sd3, 16'h3000, 1'b1, 1'b1, 1'b1);
		drain();

		// random phases, the second one with no idling at all
		phase_ref = '{16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom), 16'h8000,
			16'($urandom)};
		phase_var = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		for (int p = 0; p < 6; p++) begin
			set_config(phase_ref[p], phase_var[p]);
			idle_on = (p != 1);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random();
			drain();
		end

		repeat (PIPE_LAT + 4) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/stkqu_pkg.sv
hw/rtl/stokes_qu_rotation.sv
hw/rtl/stkqu_chk.sv
bench/stokes_qu_rotation_checker.sv
bench/stokes_qu_rotation_test.sv
